### hw/rtl/asf_pkg.sv
// shared types, constants and the key category check of the hold-to-shift filter
// no dependencies; compile first
package asf_pkg;

  // HID usage codes that bound the key categories
  localparam logic [7:0] MODIFIER_FIRST_CODE         = 8'hE0;
  localparam logic [7:0] KEY_A                       = 8'h04;
  localparam logic [7:0] KEY_Z                       = 8'h1D;
  localparam logic [7:0] KEY_1                       = 8'h1E;
  localparam logic [7:0] KEY_0                       = 8'h27;
  localparam logic [7:0] KEY_DASH                    = 8'h2D;
  localparam logic [7:0] KEY_SOLIDUS                 = 8'h38;
  localparam logic [7:0] KEY_NONUS_BACKSLASH_PIPE    = 8'h64;
  localparam logic [7:0] KEY_RIGHT_ARROW             = 8'h4F;
  localparam logic [7:0] KEY_LEFT_ARROW              = 8'h50;
  localparam logic [7:0] KEY_F1                      = 8'h3A;
  localparam logic [7:0] KEY_F12                     = 8'h45;
  localparam logic [7:0] KEY_F13                     = 8'h68;
  localparam logic [7:0] KEY_F24                     = 8'h73;

  // shift bit of the flag byte
  localparam logic [7:0] SHIFT_FLAG = 8'h08;

  // category mask bit positions
  localparam int unsigned CAT_ALL      = 0;
  localparam int unsigned CAT_LETTERS  = 1;
  localparam int unsigned CAT_NUMBERS  = 2;
  localparam int unsigned CAT_SYMBOLS  = 3;
  localparam int unsigned CAT_ARROWS   = 4;
  localparam int unsigned CAT_FUNCTION = 5;

  // field widths
  localparam int unsigned ADDR_W      = 7;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned FLAGS_W     = 8;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned CAT_W       = 6;
  localparam int unsigned ENTRY_KEY_W = ADDR_W + CODE_W + FLAGS_W + 1;

  // register port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ENABLE        = 2'd0,
    REG_HOLD_TIMEOUT  = 2'd1,
    REG_CATEGORY_MASK = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                 enable;
    logic [TIMEOUT_W-1:0] hold_timeout;
    logic [CAT_W-1:0]     category_mask;
  } cfg_t;

  localparam logic                 RST_ENABLE        = 1'b0;
  localparam logic [TIMEOUT_W-1:0] RST_HOLD_TIMEOUT  = 16'd175;
  localparam logic [CAT_W-1:0]     RST_CATEGORY_MASK = 6'd2;

  // latched input item
  typedef struct packed {
    logic               operation;
    logic [ADDR_W-1:0]  key_addr;
    logic [CODE_W-1:0]  key_code;
    logic [FLAGS_W-1:0] key_flags;
    logic               pressed;
    logic               injected;
    logic               keyboard_key;
  } evt_t;

  // result item
  typedef struct packed {
    logic [ADDR_W-1:0]  out_addr;
    logic [CODE_W-1:0]  out_code;
    logic [FLAGS_W-1:0] out_flags;
    logic               out_pressed;
    logic               long_press;
    logic               last;
  } res_t;

  function automatic logic shiftable(logic kb, logic [CODE_W-1:0] code,
                                     logic [CAT_W-1:0] mask);
    logic hit;
    hit = 1'b0;
    if (mask[CAT_ALL] && code < MODIFIER_FIRST_CODE) hit = 1'b1;
    if (mask[CAT_LETTERS] && code >= KEY_A && code <= KEY_Z) hit = 1'b1;
    if (mask[CAT_NUMBERS] && code >= KEY_1 && code <= KEY_0) hit = 1'b1;
    if (mask[CAT_SYMBOLS] &&
        ((code >= KEY_DASH && code <= KEY_SOLIDUS) || code == KEY_NONUS_BACKSLASH_PIPE)) begin
      hit = 1'b1;
    end
    if (mask[CAT_ARROWS] && code >= KEY_RIGHT_ARROW && code <= KEY_LEFT_ARROW) hit = 1'b1;
    if (mask[CAT_FUNCTION] &&
        ((code >= KEY_F1 && code <= KEY_F12) || (code >= KEY_F13 && code <= KEY_F24))) begin
      hit = 1'b1;
    end
    return kb && hit;
  endfunction

endpackage

### hw/rtl/asf_if.sv
// valid/ready channel interfaces for key events in and filtered events out
// depends on asf_pkg
interface asf_evt_if import asf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [ADDR_W-1:0]  key_addr;
  logic [CODE_W-1:0]  key_code;
  logic [FLAGS_W-1:0] key_flags;
  logic               pressed;
  logic               injected;
  logic               keyboard_key;

  modport source (
    output valid, operation, key_addr, key_code, key_flags, pressed, injected, keyboard_key,
    input  ready
  );
  modport sink (
    input  valid, operation, key_addr, key_code, key_flags, pressed, injected, keyboard_key,
    output ready
  );
endinterface

interface asf_res_if import asf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  out_addr;
  logic [CODE_W-1:0]  out_code;
  logic [FLAGS_W-1:0] out_flags;
  logic               out_pressed;
  logic               long_press;
  logic               last;

  modport source (
    output valid, out_addr, out_code, out_flags, out_pressed, long_press, last,
    input  ready
  );
  modport sink (
    input  valid, out_addr, out_code, out_flags, out_pressed, long_press, last,
    output ready
  );
endinterface

### hw/rtl/asf_cfg.sv
// apb register file: enable, hold timeout and category mask
// depends on asf_pkg
module asf_cfg import asf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_ENABLE:        cfg_d.enable        = pwdata[0];
        REG_HOLD_TIMEOUT:  cfg_d.hold_timeout  = pwdata[TIMEOUT_W-1:0];
        REG_CATEGORY_MASK: cfg_d.category_mask = pwdata[CAT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENABLE:        prdata = APB_DATA_W'(cfg_q.enable);
      REG_HOLD_TIMEOUT:  prdata = APB_DATA_W'(cfg_q.hold_timeout);
      REG_CATEGORY_MASK: prdata = APB_DATA_W'(cfg_q.category_mask);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= RST_ENABLE;
      cfg_q.hold_timeout  <= RST_HOLD_TIMEOUT;
      cfg_q.category_mask <= RST_CATEGORY_MASK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/asf_queue_mem.sv
// pending-event queue storage: one write port, one read port, registered read data
// no package dependency
module asf_queue_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 40,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/asf_ctrl.sv
// sequencer: evaluates each item against the queue head, appends, flushes the queue
// and drives the output register; depends on asf_pkg and asf_if
module asf_ctrl import asf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TIME_BITS   = 16,
  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned ENTRY_W = TIME_BITS + ENTRY_KEY_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  asf_evt_if.sink            in_ch,
  asf_res_if.source          out_ch,
  input  cfg_t               cfg_i,
  output logic               mem_we_o,
  output logic [IDX_W-1:0]   mem_waddr_o,
  output logic [ENTRY_W-1:0] mem_wdata_o,
  output logic               mem_re_o,
  output logic [IDX_W-1:0]   mem_raddr_o,
  input  logic [ENTRY_W-1:0] mem_rdata_i
);

  localparam int unsigned CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EVAL    = 5'b00010,
    S_FL_RD   = 5'b00100,
    S_FL_WR   = 5'b01000,
    S_EMIT_IN = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  evt_t                 item_q;
  logic [TIME_BITS-1:0] tick_q, tick_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 long_q, long_d;
  logic                 post_append_q, post_append_d;
  logic                 post_emit_q, post_emit_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 res_q, res_d;

  logic                 in_xfer;
  logic                 slot_free;
  logic [TIME_BITS-1:0] head_time;
  logic [ADDR_W-1:0]    head_addr;
  logic [CODE_W-1:0]    head_code;
  logic [FLAGS_W-1:0]   head_flags;
  logic                 head_pressed;
  logic [TIME_BITS-1:0] age;
  logic                 timeout_hit;
  logic                 can_hold;
  logic                 entry_last;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_q || out_ch.ready;

  assign {head_time, head_addr, head_code, head_flags, head_pressed} = mem_rdata_i;

  assign age         = tick_q - head_time;
  assign timeout_hit = CMP_W'(age) > CMP_W'(cfg_i.hold_timeout);
  assign can_hold    = item_q.pressed &&
                       shiftable(item_q.keyboard_key, item_q.key_code, cfg_i.category_mask);
  assign entry_last  = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  assign mem_wdata_o = {tick_q, item_q.key_addr, item_q.key_code, item_q.key_flags,
                        item_q.pressed};

  always_comb begin
    state_d       = state_q;
    tick_d        = tick_q;
    count_d       = count_q;
    idx_d         = idx_q;
    long_d        = long_q;
    post_append_d = post_append_q;
    post_emit_d   = post_emit_q;
    out_valid_d   = out_valid_q && !out_ch.ready;
    res_d         = res_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = count_q[IDX_W-1:0];
    mem_re_o      = 1'b0;
    mem_raddr_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          // fetch the head for the decision in the next cycle
          mem_re_o = 1'b1;
          if (in_ch.operation) begin
            tick_d = tick_q + TIME_BITS'(1);
          end
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        if (item_q.operation) begin
          if (count_q != '0 && timeout_hit) begin
            long_d        = 1'b1;
            post_append_d = 1'b0;
            post_emit_d   = 1'b0;
            idx_d         = '0;
            state_d       = S_FL_RD;
          end else begin
            state_d = S_IDLE;
          end
        end else if (item_q.injected || !cfg_i.enable) begin
          state_d = S_EMIT_IN;
        end else if (count_q != '0) begin
          if (item_q.pressed || item_q.key_addr == head_addr ||
              count_q == CNT_W'(QUEUE_DEPTH)) begin
            long_d        = 1'b0;
            post_append_d = can_hold;
            post_emit_d   = !can_hold;
            idx_d         = '0;
            state_d       = S_FL_RD;
          end else begin
            // release of another key queues behind the held press
            mem_we_o = 1'b1;
            count_d  = count_q + CNT_W'(1);
            state_d  = S_IDLE;
          end
        end else if (can_hold) begin
          mem_we_o = 1'b1;
          count_d  = count_q + CNT_W'(1);
          state_d  = S_IDLE;
        end else begin
          state_d = S_EMIT_IN;
        end
      end

      S_FL_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q;
        state_d     = S_FL_WR;
      end

      S_FL_WR: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          res_d.out_addr    = head_addr;
          res_d.out_code    = head_code;
          res_d.out_flags   = long_q ? (head_flags ^ SHIFT_FLAG) : head_flags;
          res_d.out_pressed = head_pressed;
          res_d.long_press  = long_q;
          res_d.last        = entry_last && !post_emit_q;
          long_d            = 1'b0;
          idx_d             = idx_q + IDX_W'(1);
          if (entry_last) begin
            // queue is empty now; a new held press takes entry zero
            if (post_append_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              count_d     = CNT_W'(1);
            end else begin
              count_d = '0;
            end
            state_d = post_emit_q ? S_EMIT_IN : S_IDLE;
          end else begin
            state_d = S_FL_RD;
          end
        end
      end

      S_EMIT_IN: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          res_d.out_addr    = item_q.key_addr;
          res_d.out_code    = item_q.key_code;
          res_d.out_flags   = item_q.key_flags;
          res_d.out_pressed = item_q.pressed;
          res_d.long_press  = 1'b0;
          res_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      tick_q        <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      long_q        <= 1'b0;
      post_append_q <= 1'b0;
      post_emit_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      tick_q        <= tick_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      long_q        <= long_d;
      post_append_q <= post_append_d;
      post_emit_q   <= post_emit_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.operation    <= in_ch.operation;
      item_q.key_addr     <= in_ch.key_addr;
      item_q.key_code     <= in_ch.key_code;
      item_q.key_flags    <= in_ch.key_flags;
      item_q.pressed      <= in_ch.pressed;
      item_q.injected     <= in_ch.injected;
      item_q.keyboard_key <= in_ch.keyboard_key;
    end
    res_q <= res_d;
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.out_addr    = res_q.out_addr;
  assign out_ch.out_code    = res_q.out_code;
  assign out_ch.out_flags   = res_q.out_flags;
  assign out_ch.out_pressed = res_q.out_pressed;
  assign out_ch.long_press  = res_q.long_press;
  assign out_ch.last        = res_q.last;

endmodule

### hw/rtl/auto_shift_key_event_filter_core.sv
// top level of the hold-to-shift key event filter
// depends on asf_pkg, asf_if, asf_cfg, asf_queue_mem and asf_ctrl
//
// usage:
// - in_ch carries key-switch events and time ticks (operation = 1); a transfer
//   happens when valid and ready are both high
// - out_ch carries the emitted events; the final event caused by one input item
//   has last set, and an item may cause none at all (held press, quiet tick)
// - registers sit on the apb port: enable at 0x0, hold_timeout at 0x4,
//   category_mask at 0x8; pready is tied high, write them only while idle
// - one item is worked on at a time: ready drops for the cycles after a transfer
// - an item goes through S_EVAL; a passed-through event is then loaded into the output
//   register in S_EMIT_IN; a flush reads each queued entry from the queue memory in
//   S_FL_RD and loads it into the output register in S_FL_WR, then the event itself
//   follows through S_EMIT_IN if it is not held
// - the output register decouples the sides: a new item is taken while the last
//   result still waits; if the receiver stalls, the flush pauses until it drains
// - reset empties the queue (count to zero), clears the tick counter and loads the
//   register defaults; the queue memory itself is not cleared, entries at or above
//   the count are never used
// - only one read or write of the queue happens per cycle and the flow is strictly
//   sequential, so no two accesses to the same entry overlap
module auto_shift_key_event_filter_core import asf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  asf_evt_if.sink               in_ch,
  asf_res_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENTRY_W = TIME_BITS + ENTRY_KEY_W;

  cfg_t               cfg;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // configuration registers
  asf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // held press and the releases queued behind it: {time, addr, code, flags, pressed}
  asf_queue_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_queue_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // decision, flush sequencing and output register
  asf_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_i       (cfg),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

### hw/rtl/asf_checker.sv
// port-level checks of the hold-to-shift filter, bound to the top level
// depends on auto_shift_key_event_filter_core
module asf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_pressed_i,
  input logic long_press_i,
  input logic last_i
);

  // one item at a time: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while previous item still in work");

  // when ready for a new item, any waiting result closes the previous item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_i && out_valid_i) |-> last_i)
    else $error("new item accepted before all results of the last one were loaded");

  // only a held press can leave as a long press
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && long_press_i) |-> out_pressed_i)
    else $error("long press flag on a release event");

  // stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(last_i)))
    else $error("stalled result dropped or changed");

endmodule

bind auto_shift_key_event_filter_core asf_checker u_asf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_pressed_i (out_ch.out_pressed),
  .long_press_i  (out_ch.long_press),
  .last_i        (out_ch.last)
);

### tb/auto_shift_key_event_filter_core_test.sv
// self-checking testbench for the hold-to-shift key event filter core
// depends on asf_pkg, asf_if and the rtl of auto_shift_key_event_filter_core
// a built-in predictor forecasts every emitted event, the apb port sets up each phase
`timescale 1ns / 1ps

module auto_shift_key_event_filter_core_test;
  import asf_pkg::*;

  localparam int unsigned QDEPTH       = 8;
  localparam int unsigned TBITS        = 16;
  localparam int unsigned POOL_KEYS    = 12;
  localparam int unsigned QUIET_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // operation field of an input item
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  asf_evt_if in_ch ();
  asf_res_if out_ch ();

  auto_shift_key_event_filter_core #(
    .QUEUE_DEPTH(QDEPTH),
    .TIME_BITS  (TBITS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #6 clk_i = ~clk_i;

  // idle odds in percent for both sides of the event stream
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  int unsigned items_sent;
  int unsigned events_checked;
  int unsigned long_seen;
  int unsigned reg_writes;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // predictor state: register copies, held events, tick counter
  logic                 cfg_enable;
  logic [TIMEOUT_W-1:0] cfg_timeout;
  logic [CAT_W-1:0]     cfg_mask;

  logic [TBITS-1:0]   held_time    [QDEPTH];
  logic [ADDR_W-1:0]  held_addr    [QDEPTH];
  logic [CODE_W-1:0]  held_code    [QDEPTH];
  logic [FLAGS_W-1:0] held_flags   [QDEPTH];
  logic               held_pressed [QDEPTH];
  int unsigned        held_count;
  logic [TBITS-1:0]   tick_now;

  // events caused by the item being forecast, then the ones still due at the output
  res_t batch[$];
  res_t due_events[$];

  // typing model: a small pool of keys with their codes and up/down state
  logic               key_down  [POOL_KEYS];
  logic [CODE_W-1:0]  pool_code [POOL_KEYS];
  int unsigned        pool_base;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // category membership of a code, one bit per mask bit
  function automatic logic category_hit(input logic kb, input logic [CODE_W-1:0] code);
    logic [CAT_W-1:0] cats;
    cats = '0;
    cats[CAT_ALL]      = (code < MODIFIER_FIRST_CODE);
    cats[CAT_LETTERS]  = (code >= KEY_A) && (code <= KEY_Z);
    cats[CAT_NUMBERS]  = (code >= KEY_1) && (code <= KEY_0);
    cats[CAT_SYMBOLS]  = ((code >= KEY_DASH) && (code <= KEY_SOLIDUS)) ||
                         (code == KEY_NONUS_BACKSLASH_PIPE);
    cats[CAT_ARROWS]   = (code >= KEY_RIGHT_ARROW) && (code <= KEY_LEFT_ARROW);
    cats[CAT_FUNCTION] = ((code >= KEY_F1) && (code <= KEY_F12)) ||
                         ((code >= KEY_F13) && (code <= KEY_F24));
    return kb && (|(cats & cfg_mask));
  endfunction

  task automatic add_event(input logic [ADDR_W-1:0] a, input logic [CODE_W-1:0] c,
                           input logic [FLAGS_W-1:0] f, input logic p, input logic lp);
    res_t r;
    r.out_addr    = a;
    r.out_code    = c;
    r.out_flags   = f;
    r.out_pressed = p;
    r.long_press  = lp;
    r.last        = 1'b0;
    batch.push_back(r);
  endtask

  // emit the oldest held event, shift toggled for a long press, and close the gap
  task automatic release_head(input logic lp);
    logic [FLAGS_W-1:0] f;
    int unsigned        i;
    if (held_count == 0) return;
    f = held_flags[0];
    if (lp) f = f ^ SHIFT_FLAG;
    add_event(held_addr[0], held_code[0], f, held_pressed[0], lp);
    for (i = 1; i < held_count; i++) begin
      held_time[i-1]    = held_time[i];
      held_addr[i-1]    = held_addr[i];
      held_code[i-1]    = held_code[i];
      held_flags[i-1]   = held_flags[i];
      held_pressed[i-1] = held_pressed[i];
    end
    held_count--;
  endtask

  function automatic logic head_release_waiting();
    int unsigned i;
    for (i = 1; i < held_count; i++) begin
      if (held_addr[i] == held_addr[0]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // releases leave until a press whose own release is not yet held sits at the head
  task automatic flush_releases();
    logic stuck;
    stuck = 1'b0;
    while (held_count > 0 && !stuck) begin
      if (!held_pressed[0] || head_release_waiting()) release_head(1'b0);
      else stuck = 1'b1;
    end
  endtask

  task automatic hold_event(input evt_t it);
    held_time[held_count]    = tick_now;
    held_addr[held_count]    = it.key_addr;
    held_code[held_count]    = it.key_code;
    held_flags[held_count]   = it.key_flags;
    held_pressed[held_count] = it.pressed;
    held_count++;
  endtask

  // works out the events one accepted item causes and queues them as due
  task automatic forecast_events(input evt_t it);
    res_t             r;
    logic [TBITS-1:0] age;
    logic             taken;
    batch.delete();
    taken = 1'b0;
    if (it.operation == OP_TICK) begin
      tick_now = tick_now + 1'b1;
      age      = tick_now - held_time[0];
      if (held_count > 0 && age > cfg_timeout) begin
        release_head(1'b1);
        flush_releases();
      end
    end else if (it.injected || !cfg_enable) begin
      add_event(it.key_addr, it.key_code, it.key_flags, it.pressed, 1'b0);
    end else begin
      if (held_count > 0) begin
        // another press, the head's own release or a full queue lets the head go
        if (it.pressed || it.key_addr == held_addr[0] || held_count >= QDEPTH) begin
          release_head(1'b0);
          flush_releases();
        end else begin
          hold_event(it);
          taken = 1'b1;
        end
      end
      if (!taken) begin
        if (it.pressed && category_hit(it.keyboard_key, it.key_code) && held_count < QDEPTH)
          hold_event(it);
        else
          add_event(it.key_addr, it.key_code, it.key_flags, it.pressed, 1'b0);
      end
    end
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[i]) due_events.push_back(batch[i]);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls and the event checker
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch on event %0d, expected %0h, got %0h",
               $time, name, events_checked, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : event_checker
    res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (due_events.size() == 0) begin
        $display("%0t ns: unexpected event, expected none, got addr %0h code %0h flags %0h",
                 $time, out_ch.out_addr, out_ch.out_code, out_ch.out_flags);
        mismatch_count++;
      end else begin
        want = due_events.pop_front();
        check_field("out_addr", 32'(want.out_addr), 32'(out_ch.out_addr));
        check_field("out_code", 32'(want.out_code), 32'(out_ch.out_code));
        check_field("out_flags", 32'(want.out_flags), 32'(out_ch.out_flags));
        check_field("out_pressed", 32'(want.out_pressed), 32'(out_ch.out_pressed));
        check_field("long_press", 32'(want.long_press), 32'(out_ch.long_press));
        check_field("last", 32'(want.last), 32'(out_ch.last));
        if (want.long_press) long_seen++;
      end
      events_checked++;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t ns: run timed out after %0d cycles, %0d events still due",
             $time, cycle_count, due_events.size());
    $display("[auto_shift_key_event_filter_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  function automatic logic [APB_ADDR_W-1:0] reg_addr(input cfg_reg_e r);
    return {r, 2'b00};
  endfunction

  task automatic reg_write(input cfg_reg_e r, input logic [APB_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(r);
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      REG_ENABLE:        cfg_enable  = v[0];
      REG_HOLD_TIMEOUT:  cfg_timeout = v[TIMEOUT_W-1:0];
      REG_CATEGORY_MASK: cfg_mask    = v[CAT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic reg_read_check(input cfg_reg_e r, input logic [APB_DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(r);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t ns: register %s read mismatch, expected %0h, got %0h",
               $time, r.name(), want, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic evt_t key_item(input logic [ADDR_W-1:0] a, input logic [CODE_W-1:0] c,
                                    input logic [FLAGS_W-1:0] f, input logic p,
                                    input logic inj, input logic kb);
    evt_t it;
    it.operation    = OP_KEY;
    it.key_addr     = a;
    it.key_code     = c;
    it.key_flags    = f;
    it.pressed      = p;
    it.injected     = inj;
    it.keyboard_key = kb;
    return it;
  endfunction

  function automatic evt_t noise_key();
    return key_item(ADDR_W'($urandom_range(127, 0)), CODE_W'($urandom_range(255, 0)),
                    FLAGS_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                    1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endfunction

  // a tick carries random junk in the fields it ignores
  function automatic evt_t tick_item();
    evt_t it;
    it = noise_key();
    it.operation = OP_TICK;
    return it;
  endfunction

  // codes spread over every category, the modifiers and the category borders
  function automatic logic [CODE_W-1:0] pick_code();
    logic [CODE_W-1:0] c;
    case ($urandom_range(7, 0))
      0: c = CODE_W'($urandom_range(KEY_Z, KEY_A));
      1: c = CODE_W'($urandom_range(KEY_0, KEY_1));
      2: c = ($urandom_range(3, 0) == 0) ? KEY_NONUS_BACKSLASH_PIPE :
             CODE_W'($urandom_range(KEY_SOLIDUS, KEY_DASH));
      3: c = CODE_W'($urandom_range(KEY_LEFT_ARROW, KEY_RIGHT_ARROW));
      4: c = ($urandom_range(1, 0) == 1) ? CODE_W'($urandom_range(KEY_F12, KEY_F1)) :
             CODE_W'($urandom_range(KEY_F24, KEY_F13));
      5: c = CODE_W'($urandom_range(255, MODIFIER_FIRST_CODE));
      6: begin
        case ($urandom_range(13, 0))
          0:  c = KEY_A;
          1:  c = KEY_Z;
          2:  c = KEY_1;
          3:  c = KEY_0;
          4:  c = KEY_DASH;
          5:  c = KEY_SOLIDUS;
          6:  c = KEY_NONUS_BACKSLASH_PIPE;
          7:  c = KEY_RIGHT_ARROW;
          8:  c = KEY_LEFT_ARROW;
          9:  c = KEY_F1;
          10: c = KEY_F12;
          11: c = KEY_F13;
          12: c = KEY_F24;
          default: c = MODIFIER_FIRST_CODE;
        endcase
        // one below, on, or one above the border
        c = c + CODE_W'($urandom_range(2, 0)) - 8'd1;
      end
      default: c = CODE_W'($urandom_range(255, 0));
    endcase
    return c;
  endfunction

  // a code the current mask would hold, where a few tries find one
  function automatic logic [CODE_W-1:0] pick_held_code();
    logic [CODE_W-1:0] c;
    int unsigned       tries;
    c = pick_code();
    for (tries = 0; tries < 8 && !category_hit(1'b1, c); tries++) c = pick_code();
    return c;
  endfunction

  // one item over the input channel; valid stays up when the next item follows at once
  task automatic send_item(input evt_t it);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= it.operation;
    in_ch.key_addr     <= it.key_addr;
    in_ch.key_code     <= it.key_code;
    in_ch.key_flags    <= it.key_flags;
    in_ch.pressed      <= it.pressed;
    in_ch.injected     <= it.injected;
    in_ch.keyboard_key <= it.keyboard_key;
    do @(posedge clk_i); while (!in_ch.ready);
    forecast_events(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // all due events out, then room for an item that causes none to finish
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register defaults, pass-through while disabled, a tick on an empty queue
  task automatic test_reset_state();
    reg_read_check(REG_ENABLE, 32'(RST_ENABLE));
    reg_read_check(REG_HOLD_TIMEOUT, 32'(RST_HOLD_TIMEOUT));
    reg_read_check(REG_CATEGORY_MASK, 32'(RST_CATEGORY_MASK));
    send_item(key_item(7'd1, KEY_A, 8'h00, 1'b1, 1'b0, 1'b1));
    send_item(tick_item());
  endtask

  // held letter, a foreign release behind it, then its own release
  task automatic test_own_release();
    wait_quiet();
    reg_write(REG_ENABLE, 32'd1);
    send_item(key_item(7'd127, KEY_Z, 8'hFF, 1'b1, 1'b0, 1'b1));
    send_item(key_item(7'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
    send_item(key_item(7'd127, KEY_Z, 8'hFF, 1'b0, 1'b0, 1'b1));
  endtask

  // an injected event slips past the held press, a plain press pushes it out
  task automatic test_press_flush();
    send_item(key_item(7'd10, KEY_A, 8'h5A, 1'b1, 1'b0, 1'b1));
    send_item(key_item(7'd11, KEY_A + 8'd1, 8'h3C, 1'b1, 1'b1, 1'b1));
    send_item(key_item(7'd12, KEY_1, 8'hA5, 1'b1, 1'b0, 1'b0));
  endtask

  // long press: the shift bit already set in the flags gets cleared
  task automatic test_timeout();
    wait_quiet();
    reg_write(REG_HOLD_TIMEOUT, 32'd1);
    reg_write(REG_CATEGORY_MASK, 32'h3F);
    send_item(key_item(7'd20, KEY_F1, SHIFT_FLAG, 1'b1, 1'b0, 1'b1));
    send_item(key_item(7'd21, KEY_Z, 8'h00, 1'b0, 1'b0, 1'b1));
    send_item(tick_item());
    send_item(tick_item());
  endtask

  // queue fills with releases; the next one empties it in a single run of nine
  task automatic test_queue_full();
    int unsigned j;
    wait_quiet();
    reg_write(REG_HOLD_TIMEOUT, 32'hFFFF);
    reg_write(REG_CATEGORY_MASK, 32'(1 << CAT_ARROWS));
    send_item(key_item(7'd40, KEY_LEFT_ARROW, 8'h81, 1'b1, 1'b0, 1'b1));
    for (j = 1; j <= QDEPTH; j++)
      send_item(key_item(ADDR_W'(40 + j), CODE_W'(KEY_A + j), FLAGS_W'(j), 1'b0, 1'b0, 1'b1));
  endtask

  // disabling leaves a held press in place, and a tick still times it out
  task automatic test_disable_pending();
    wait_quiet();
    reg_write(REG_HOLD_TIMEOUT, 32'd0);
    reg_write(REG_CATEGORY_MASK, 32'(1 << CAT_SYMBOLS));
    send_item(key_item(7'd50, KEY_NONUS_BACKSLASH_PIPE, 8'h01, 1'b1, 1'b0, 1'b1));
    wait_quiet();
    reg_write(REG_ENABLE, 32'd0);
    send_item(key_item(7'd51, KEY_DASH, 8'h02, 1'b1, 1'b0, 1'b1));
    send_item(tick_item());
  endtask

  // random typing: rolled bursts that fill the queue, single keys, ticks and noise
  task automatic test_random_typing(input int unsigned n_items, input int unsigned src_pct,
                                    input int unsigned snk_pct, input logic en,
                                    input logic [TIMEOUT_W-1:0] timeout,
                                    input logic [CAT_W-1:0] mask);
    int unsigned       stop_at;
    int unsigned       k;
    int unsigned       j;
    int unsigned       idx;
    int unsigned       n_ticks;
    logic [ADDR_W-1:0] roll_base;
    logic [CODE_W-1:0] tgt_code;
    wait_quiet();
    reg_write(REG_ENABLE, 32'(en));
    reg_write(REG_HOLD_TIMEOUT, 32'(timeout));
    reg_write(REG_CATEGORY_MASK, 32'(mask));
    reg_read_check(REG_ENABLE, 32'(en));
    reg_read_check(REG_HOLD_TIMEOUT, 32'(timeout));
    reg_read_check(REG_CATEGORY_MASK, 32'(mask));
    src_idle_pct  = src_pct;
    sink_idle_pct = snk_pct;
    pool_base     = $urandom_range(127 - POOL_KEYS, 0);
    for (j = 0; j < POOL_KEYS; j++) begin
      pool_code[j] = pick_code();
      key_down[j]  = 1'b0;
    end
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(19, 0))
        0, 1, 2, 3: begin
          // modifiers go down, a held key follows, the modifiers come up behind it
          k         = $urandom_range(QDEPTH + 1, 2);
          roll_base = ADDR_W'($urandom_range(127 - QDEPTH - 1, 0));
          tgt_code  = pick_held_code();
          for (j = 1; j <= k; j++)
            send_item(key_item(ADDR_W'(roll_base + j),
                               CODE_W'(MODIFIER_FIRST_CODE + j - 1),
                               FLAGS_W'($urandom_range(255, 0)), 1'b1, 1'b0,
                               1'($urandom_range(1, 0))));
          send_item(key_item(roll_base, tgt_code, FLAGS_W'($urandom_range(255, 0)), 1'b1,
                             1'b0, 1'b1));
          for (j = 1; j <= k; j++) begin
            if ($urandom_range(3, 0) == 0) send_item(tick_item());
            send_item(key_item(ADDR_W'(roll_base + j),
                               CODE_W'(MODIFIER_FIRST_CODE + j - 1),
                               FLAGS_W'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b1));
          end
          // either a quick tap or a hold long enough to run out a timeout below twelve
          if ($urandom_range(1, 0) == 1) begin
            n_ticks = (timeout < 10) ? int'(timeout) + 2 : 12;
            repeat (n_ticks) send_item(tick_item());
          end
          send_item(key_item(roll_base, tgt_code, FLAGS_W'($urandom_range(255, 0)), 1'b0,
                             1'b0, 1'b1));
        end
        4, 5, 6, 7, 8, 9: send_item(tick_item());
        10: send_item(noise_key());
        default: begin
          idx = $urandom_range(POOL_KEYS - 1, 0);
          send_item(key_item(ADDR_W'(pool_base + idx), pool_code[idx],
                             FLAGS_W'($urandom_range(255, 0)), !key_down[idx],
                             ($urandom_range(11, 0) == 0), ($urandom_range(9, 0) != 0)));
          key_down[idx] = !key_down[idx];
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_KEY;
    in_ch.key_addr      = '0;
    in_ch.key_code      = '0;
    in_ch.key_flags     = '0;
    in_ch.pressed       = 1'b0;
    in_ch.injected      = 1'b0;
    in_ch.keyboard_key  = 1'b0;
    out_ch.ready        = 1'b0;
    src_idle_pct        = 25;
    sink_idle_pct       = 69;
    items_sent          = 0;
    events_checked      = 0;
    long_seen           = 0;
    reg_writes          = 0;
    mismatch_count      = 0;
    cfg_enable          = RST_ENABLE;
    cfg_timeout         = RST_HOLD_TIMEOUT;
    cfg_mask            = RST_CATEGORY_MASK;
    held_count          = 0;
    tick_now            = '0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_state();
    test_own_release();
    test_press_flush();
    test_timeout();
    test_queue_full();
    test_disable_pending();

    // sender light, receiver heavy; then the reverse; then no idling at all
    test_random_typing(80, 25, 69, 1'b1, TIMEOUT_W'($urandom_range(6, 0)),
                       CAT_W'($urandom_range(63, 1)));
    test_random_typing(80, 69, 25, 1'b1, '0, '1);
    test_random_typing(45, 0, 0, 1'b1, '1, CAT_W'($urandom_range(63, 1)));
    test_random_typing(30, 0, 0, 1'b0, TIMEOUT_W'(4), '0);
    wait_quiet();

    $display("run covered %0d input items and %0d emitted events (%0d long presses)",
             items_sent, events_checked, long_seen);
    $display("%0d register writes over directed and random phases, %0d mismatches",
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[auto_shift_key_event_filter_core] OK");
    end else begin
      $display("[auto_shift_key_event_filter_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/asf_pkg.sv
hw/rtl/asf_if.sv
hw/rtl/asf_cfg.sv
hw/rtl/asf_queue_mem.sv
hw/rtl/asf_ctrl.sv
hw/rtl/auto_shift_key_event_filter_core.sv
hw/rtl/asf_checker.sv
tb/auto_shift_key_event_filter_core_test.sv
